>>> rtl/core/pwl_lut_pkg.sv
// ----------------------------------------------------------------------------
// pwl_lut_pkg
// Shared types and constants for the piecewise-linear table lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package pwl_lut_pkg;

   // request kinds
   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   // register index of point_count, taken from paddr[2]
   localparam logic REG_POINT_COUNT = 1'b0;

   // configuration register width
   localparam int unsigned COUNT_W = 9;

   // reset value of point_count
   localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd2;

   // lookup sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_FIRST,
      ST_SCAN,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_PUSH
   } state_type;

   // divider status towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

>>> rtl/core/pwl_lut_div.sv
// ----------------------------------------------------------------------------
// pwl_lut_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pwl_lut_div #(
   parameter int unsigned NUM_W = 33,
   parameter int unsigned DEN_W = 16
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   input  wire  [NUM_W-1:0]              numerator,
   input  wire  [DEN_W-1:0]              denominator,
   output pwl_lut_pkg::div_stat_type     status,
   output logic [NUM_W-1:0]              quotient
);

   import pwl_lut_pkg::*;

   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff,  quo_in;
   logic [DEN_W-1:0] rem_ff,  rem_in;
   logic [DEN_W-1:0] den_ff,  den_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   trial_diff;
   logic             fits;

   // shift in the next numerator bit and try the subtraction
   assign trial      = {rem_ff, quo_ff[NUM_W-1]};
   assign trial_diff = trial - {1'b0, den_ff};
   assign fits       = (trial >= {1'b0, den_ff});

   // step control
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = numerator;
         rem_in  = '0;
         den_in  = denominator;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

`default_nettype wire

>>> rtl/core/piecewise_linear_table_lookup.sv
// ----------------------------------------------------------------------------
// piecewise_linear_table_lookup
// Breakpoint table with a sequential segment scan and serial interpolation.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    kind, point_index, x_value, y_value
//  rsp      out        rsp_valid/stall    y_out, clipped
//  csr      in/out     APB psel/penable   point_count at byte address 0
//
//  A load request is taken in the idle state. A lookup reads one table entry
//  per cycle, then steps through a multiply, a divider start, a wait on the
//  serial divider and a push into the output register; clamped, flat or
//  zero-spread results skip the arithmetic, and the push waits while the
//  output is stalled. Reset is synchronous; the table is not cleared.
//  Requests stall while a lookup is in progress.
//
`default_nettype none

module piecewise_linear_table_lookup #(
   parameter int unsigned MAX_POINTS  = 256,
   parameter int unsigned VALUE_WIDTH = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   // requests
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire                                req_kind,
   input  wire  [7:0]                         req_point_index,
   input  wire  signed [VALUE_WIDTH-1:0]      req_x_value,
   input  wire  signed [VALUE_WIDTH-1:0]      req_y_value,
   // results
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic signed [VALUE_WIDTH-1:0]      rsp_y_out,
   output logic                               rsp_clipped,
   // configuration
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire  [2:0]                         csr_paddr,
   input  wire  [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   import pwl_lut_pkg::*;

   localparam int unsigned VW    = VALUE_WIDTH;
   localparam int unsigned AW    = $clog2(MAX_POINTS);
   localparam int unsigned NUM_W = 2 * VW + 1;

   // configuration
   logic [COUNT_W-1:0] point_count_ff;
   logic [31:0]        count_ext;
   logic [AW-1:0]      last_idx;

   // sequencer
   state_type          state_ff, state_in;
   logic [AW-1:0]      hi_idx_ff;
   logic [AW-1:0]      rd_addr;
   logic               div_start;

   // table memory
   logic [VW-1:0]      mem_x [MAX_POINTS];
   logic [VW-1:0]      mem_y [MAX_POINTS];
   logic signed [VW-1:0] rd_x_ff, rd_y_ff;
   logic               load_we;

   // scan registers
   logic signed [VW-1:0] x_ff;
   logic signed [VW-1:0] lo_x_ff, lo_y_ff;
   logic signed [VW-1:0] first_x_ff, first_y_ff;

   // segment arithmetic
   logic [VW:0]        dx_full, dy_full, off_full;
   logic               in_seg;
   logic [VW-1:0]      off_ff, dx_ff;
   logic [VW:0]        dy_mag_ff;
   logic               dy_neg_ff;
   logic [NUM_W-1:0]   prod_ff;
   logic [NUM_W-1:0]   quotient;
   div_stat_type       div_stat;
   logic [VW:0]        q_short;
   logic [VW:0]        interp;

   // pending result and output register
   logic signed [VW-1:0] res_y_ff;
   logic               res_clip_ff;
   logic               rsp_valid_ff;
   logic signed [VW-1:0] rsp_y_ff;
   logic               rsp_clip_ff;
   logic               out_free;

   // ------------------------------------------------------------------------
   // configuration port
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= COUNT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[2] == REG_POINT_COUNT)) begin
         point_count_ff <= csr_pwdata[COUNT_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_POINT_COUNT) begin
         csr_prdata = 32'(point_count_ff);
      end
   end

   // index of the last breakpoint in use, count clamped to its range
   assign count_ext = 32'(point_count_ff);

   always_comb begin
      if (count_ext > 32'(MAX_POINTS)) begin
         last_idx = AW'(MAX_POINTS - 1);
      end else if (count_ext < 32'd2) begin
         last_idx = AW'(1);
      end else begin
         last_idx = AW'(count_ext - 32'd1);
      end
   end

   // ------------------------------------------------------------------------
   // table memory, one write and one registered read port
   assign load_we = (state_ff == ST_IDLE) && req_valid && (req_kind == KIND_LOAD) &&
                    (32'(req_point_index) < 32'(MAX_POINTS));

   always_ff @(posedge clock) begin
      if (load_we) begin
         mem_x[AW'(req_point_index)] <= req_x_value;
         mem_y[AW'(req_point_index)] <= req_y_value;
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
   end

   // ------------------------------------------------------------------------
   // segment test on the current pair of entries
   assign dx_full  = {rd_x_ff[VW-1], rd_x_ff} - {lo_x_ff[VW-1], lo_x_ff};
   assign dy_full  = {rd_y_ff[VW-1], rd_y_ff} - {lo_y_ff[VW-1], lo_y_ff};
   assign off_full = {x_ff[VW-1], x_ff} - {lo_x_ff[VW-1], lo_x_ff};
   assign in_seg   = (x_ff >= lo_x_ff) && (x_ff <= rd_x_ff);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ------------------------------------------------------------------------
   // sequencer next state and strobes
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      rd_addr   = hi_idx_ff + AW'(1);
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            rd_addr   = '0;
            if (req_valid && (req_kind == KIND_LOOKUP)) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            rd_addr  = '0;
            state_in = ST_FIRST;
         end
         ST_FIRST: begin
            rd_addr  = AW'(1);
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (in_seg) begin
               if ((dx_full == '0) || (dy_full == '0)) begin
                  state_in = ST_PUSH;
               end else begin
                  state_in = ST_MUL;
               end
            end else if (hi_idx_ff == last_idx) begin
               state_in = ST_PUSH;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------------
   // scan and arithmetic registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            x_ff <= req_x_value;
         end
         ST_FIRST: begin
            lo_x_ff    <= rd_x_ff;
            lo_y_ff    <= rd_y_ff;
            first_x_ff <= rd_x_ff;
            first_y_ff <= rd_y_ff;
            hi_idx_ff  <= AW'(1);
         end
         ST_SCAN: begin
            // keep the left end of a bracketing segment for the interpolation
            if (!in_seg) begin
               lo_x_ff   <= rd_x_ff;
               lo_y_ff   <= rd_y_ff;
               hi_idx_ff <= hi_idx_ff + AW'(1);
            end
            off_ff    <= off_full[VW-1:0];
            dx_ff     <= dx_full[VW-1:0];
            dy_neg_ff <= dy_full[VW];
            dy_mag_ff <= dy_full[VW] ? (~dy_full + (VW+1)'(1)) : dy_full;
            // flat, zero spread or clamp results go straight out
            if (in_seg) begin
               res_y_ff    <= lo_y_ff;
               res_clip_ff <= 1'b1;
            end else if (x_ff < first_x_ff) begin
               res_y_ff    <= first_y_ff;
               res_clip_ff <= 1'b1;
            end else begin
               res_y_ff    <= rd_y_ff;
               res_clip_ff <= 1'b1;
            end
         end
         ST_MUL: begin
            prod_ff <= NUM_W'(off_ff) * NUM_W'(dy_mag_ff);
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               res_y_ff    <= interp[VW-1:0];
               res_clip_ff <= 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // quotient never exceeds |dy|, so VW+1 bits carry it
   assign q_short = quotient[VW:0];
   assign interp  = dy_neg_ff ? ({lo_y_ff[VW-1], lo_y_ff} - q_short)
                              : ({lo_y_ff[VW-1], lo_y_ff} + q_short);

   // serial divider for the interpolation step
   pwl_lut_div #(
      .NUM_W (NUM_W),
      .DEN_W (VW)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (prod_ff),
      .denominator (dx_ff),
      .status      (div_stat),
      .quotient    (quotient)
   );

   // ------------------------------------------------------------------------
   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_PUSH) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_PUSH) && out_free) begin
         rsp_y_ff    <= res_y_ff;
         rsp_clip_ff <= res_clip_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_y_out   = rsp_y_ff;
   assign rsp_clipped = rsp_clip_ff;

   // ------------------------------------------------------------------------
   // checks
`ifndef SYNTHESIS
   // divider runs only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      (div_stat.busy || div_stat.done) |-> (state_ff == ST_DIV_WAIT))
      else $error("divider active outside the divide wait state");

   // a pending result holds while the output register is occupied
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH) && rsp_valid_ff && rsp_stall |=> (state_ff == ST_PUSH))
      else $error("pending result left while output stalled");

   // a new result appears only from the holding stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_PUSH))
      else $error("result raised without a pending request");
`endif

endmodule

`default_nettype wire

>>> tb/pwl_lut_checker.sv
// ----------------------------------------------------------------------------
// pwl_lut_checker
// Watches the request, result and register ports of the piecewise-linear
// table lookup, keeps its own breakpoint table and point count, works out
// the interpolated value of every lookup request and compares each result
// against the oldest outstanding one.
// ----------------------------------------------------------------------------

module pwl_lut_checker #(
   parameter int unsigned MAX_POINTS  = 256,
   parameter int unsigned VALUE_WIDTH = 16
) (
   input  wire                            clock,
   input  wire                            reset,
   // requests
   input  wire                            req_valid,
   input  wire                            req_stall,
   input  wire                            req_kind,
   input  wire  [7:0]                     req_point_index,
   input  wire  signed [VALUE_WIDTH-1:0]  req_x_value,
   input  wire  signed [VALUE_WIDTH-1:0]  req_y_value,
   // results
   input  wire                            rsp_valid,
   input  wire                            rsp_stall,
   input  wire  signed [VALUE_WIDTH-1:0]  rsp_y_out,
   input  wire                            rsp_clipped,
   // configuration
   input  wire                            csr_psel,
   input  wire                            csr_penable,
   input  wire                            csr_pwrite,
   input  wire  [2:0]                     csr_paddr,
   input  wire  [31:0]                    csr_pwdata,
   input  wire                            csr_pready,
   // status towards the testbench top
   output int unsigned                    lookups_pending,
   output int unsigned                    mismatch_count
);

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] y_out;
      logic                          clipped;
   } lookup_result_type;

   // shadow copy of the breakpoint table and the point count
   logic signed [VALUE_WIDTH-1:0]         bp_x [MAX_POINTS];
   logic signed [VALUE_WIDTH-1:0]         bp_y [MAX_POINTS];
   logic [pwl_lut_pkg::COUNT_W-1:0]       point_count;
   lookup_result_type                     lookup_results_due [$];

   // one line per mismatch
   task automatic report_mismatch(input string what, input longint want, input longint got);
      $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
      mismatch_count++;
   endtask

   // segment scan and interpolation of one query against the shadow table
   function automatic lookup_result_type interpolate_query(
      input logic signed [VALUE_WIDTH-1:0] query
   );
      lookup_result_type res;
      int unsigned    points;
      int unsigned    seg;
      longint         xq, xl, xh, yl, dy, dx, q, yv;
      logic           found;
      if (point_count < 2)
         points = 2;
      else if (point_count > MAX_POINTS)
         points = MAX_POINTS;
      else
         points = point_count;
      xq    = query;
      found = 1'b0;
      seg   = 0;
      res   = '0;
      // first segment that brackets the query wins
      while (!found && seg + 1 < points) begin
         xl = bp_x[seg];
         xh = bp_x[seg + 1];
         if (xq >= xl && xq <= xh) begin
            found = 1'b1;
            yl    = bp_y[seg];
            yv    = bp_y[seg + 1];
            dy    = yv - yl;
            dx    = xh - xl;
            // flat segment or zero x spread return the left y
            if (dy == 0 || dx == 0) begin
               res.y_out   = yl[VALUE_WIDTH-1:0];
               res.clipped = 1'b1;
            end else begin
               q  = ((xq - xl) * ((dy < 0) ? -dy : dy)) / dx;
               yv = (dy < 0) ? yl - q : yl + q;
               res.y_out   = yv[VALUE_WIDTH-1:0];
               res.clipped = 1'b0;
            end
         end
         seg++;
      end
      // clamp below the first point, otherwise to the last point in use
      if (!found) begin
         res.clipped = 1'b1;
         xl = bp_x[0];
         if (xq < xl)
            res.y_out = bp_y[0];
         else
            res.y_out = bp_y[points - 1];
      end
      return res;
   endfunction

   // channel monitor: results first, since a result never belongs to the
   // request accepted at the same edge
   always @(posedge clock) begin : monitor
      lookup_result_type due;
      if (reset) begin
         point_count    = pwl_lut_pkg::COUNT_RESET;
         mismatch_count = 0;
         lookup_results_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (lookup_results_due.size() == 0) begin
               report_mismatch("result with no lookup outstanding, y_out", 0, rsp_y_out);
            end else begin
               due = lookup_results_due.pop_front();
               if (rsp_y_out !== due.y_out)
                  report_mismatch("y_out", due.y_out, rsp_y_out);
               if (rsp_clipped !== due.clipped)
                  report_mismatch("clipped", due.clipped, rsp_clipped);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_kind == pwl_lut_pkg::KIND_LOAD) begin
               if (req_point_index < MAX_POINTS) begin
                  bp_x[req_point_index] = req_x_value;
                  bp_y[req_point_index] = req_y_value;
               end
            end else begin
               lookup_results_due.push_back(interpolate_query(req_x_value));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[2] == pwl_lut_pkg::REG_POINT_COUNT)
            point_count = csr_pwdata[pwl_lut_pkg::COUNT_W-1:0];
      end
      lookups_pending = lookup_results_due.size();
   end

endmodule

>>> tb/piecewise_linear_table_lookup_tb.sv
// ----------------------------------------------------------------------------
// piecewise_linear_table_lookup_tb
// Drives load and lookup requests and point_count writes into the table
// lookup, with bursty requests, a wandering result stall and one long
// hold-off, while the checker alongside predicts and compares every result.
// ----------------------------------------------------------------------------

module piecewise_linear_table_lookup_tb;

   localparam int unsigned MAX_POINTS      = 256;
   localparam int unsigned VALUE_WIDTH     = 16;
   localparam int unsigned RESET_CYCLES    = 11;
   localparam int unsigned TARGET_REQUESTS = 1250;
   localparam int unsigned SETTLE_CYCLES   = 16;
   localparam int unsigned TAIL_CYCLES     = 400;
   localparam int unsigned HOLD_CYCLES     = 1500;
   localparam int unsigned QUIET_LIMIT     = 12000;
   localparam int unsigned REBUILD_MAX     = 40;
   localparam int          VALUE_MIN       = -32768;
   localparam int          VALUE_MAX       = 32767;

   // register index with nothing behind it
   localparam logic REG_SPARE = ~pwl_lut_pkg::REG_POINT_COUNT;

   typedef enum logic [1:0] {
      FLOW_FREE,
      FLOW_LIGHT,
      FLOW_HEAVY,
      FLOW_TOGGLE
   } flow_mode_type;

   logic                          clock           = 1'b0;
   logic                          reset           = 1'b1;
   logic                          req_valid       = 1'b0;
   logic                          req_kind        = pwl_lut_pkg::KIND_LOAD;
   logic [7:0]                    req_point_index = '0;
   logic signed [VALUE_WIDTH-1:0] req_x_value     = '0;
   logic signed [VALUE_WIDTH-1:0] req_y_value     = '0;
   logic                          rsp_stall       = 1'b0;
   logic                          csr_psel        = 1'b0;
   logic                          csr_penable     = 1'b0;
   logic                          csr_pwrite      = 1'b0;
   logic [2:0]                    csr_paddr       = '0;
   logic [31:0]                   csr_pwdata      = '0;

   wire                           req_stall;
   wire                           rsp_valid;
   wire  signed [VALUE_WIDTH-1:0] rsp_y_out;
   wire                           rsp_clipped;
   wire  [31:0]                   csr_prdata;
   wire                           csr_pready;

   int unsigned                   lookups_pending;
   int unsigned                   mismatch_count;

   // stimulus bookkeeping
   int                            tbl_x [MAX_POINTS];
   int unsigned                   points_in_use = 2;
   int unsigned                   burst_left    = 0;
   int unsigned                   sent_count    = 0;
   bit                            hold_request  = 1'b0;

   // receiver pattern state
   int unsigned                   hold_left = 0;
   int unsigned                   mode_left = 0;
   flow_mode_type                 flow_mode = FLOW_FREE;

   piecewise_linear_table_lookup #(
      .MAX_POINTS  (MAX_POINTS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_point_index (req_point_index),
      .req_x_value     (req_x_value),
      .req_y_value     (req_y_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_y_out       (rsp_y_out),
      .rsp_clipped     (rsp_clipped),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   pwl_lut_checker #(
      .MAX_POINTS  (MAX_POINTS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_point_index (req_point_index),
      .req_x_value     (req_x_value),
      .req_y_value     (req_y_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_y_out       (rsp_y_out),
      .rsp_clipped     (rsp_clipped),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .lookups_pending (lookups_pending),
      .mismatch_count  (mismatch_count)
   );

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int random_value();
      return int'($urandom_range(0, 65535)) + VALUE_MIN;
   endfunction

   function automatic int clamp_value(input int v);
      if (v < VALUE_MIN)
         return VALUE_MIN;
      if (v > VALUE_MAX)
         return VALUE_MAX;
      return v;
   endfunction

   // one request, offered in bursts with random gaps between them
   task automatic offer_request(input logic kind, input logic [7:0] slot,
                                input int xv, input int yv);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_point_index <= slot;
      req_x_value     <= xv[VALUE_WIDTH-1:0];
      req_y_value     <= yv[VALUE_WIDTH-1:0];
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic send_load(input logic [7:0] slot, input int xv, input int yv);
      tbl_x[slot] = xv;
      offer_request(pwl_lut_pkg::KIND_LOAD, slot, xv, yv);
   endtask

   task automatic send_lookup(input int xv);
      offer_request(pwl_lut_pkg::KIND_LOOKUP, 8'($urandom_range(0, 255)), xv, random_value());
   endtask

   // stop offering, wait for every outstanding result, then let the block settle
   task automatic drain_and_settle(input int unsigned cycles);
      req_valid <= 1'b0;
      burst_left = 0;
      while (lookups_pending != 0) @(negedge clock);
      repeat (cycles) @(negedge clock);
   endtask

   // APB write: setup phase, then access phase until pready
   task automatic write_register(input logic reg_index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // point_count write with junk in the unused upper bits
   task automatic set_point_count(input int unsigned count);
      write_register(pwl_lut_pkg::REG_POINT_COUNT, ($urandom() & ~32'h1FF) | count);
      if (count < 2)
         points_in_use = 2;
      else if (count > MAX_POINTS)
         points_in_use = MAX_POINTS;
      else
         points_in_use = count;
   endtask

   // mostly rising x with the odd repeat or step back, y random, nudged or flat
   task automatic build_table(input int unsigned points);
      int unsigned rebuilt, step_max, slot, sel;
      int          xv, yv;
      rebuilt = (points > REBUILD_MAX) ? REBUILD_MAX : points;
      case ($urandom_range(0, 2))
         0:       step_max = 4;
         1:       step_max = 300;
         default: step_max = 65535 / rebuilt;
      endcase
      xv = int'($urandom_range(0, 40000)) + VALUE_MIN;
      yv = random_value();
      for (slot = 0; slot < rebuilt; slot++) begin
         send_load(8'(slot), xv, yv);
         sel = $urandom_range(0, 19);
         if (sel == 1)
            xv = clamp_value(xv - int'($urandom_range(1, step_max)));
         else if (sel != 0)
            xv = clamp_value(xv + int'($urandom_range(1, step_max)));
         sel = $urandom_range(0, 9);
         if (sel >= 5)
            yv = random_value();
         else if (sel != 0)
            yv = clamp_value(yv + int'($urandom_range(0, 2000)) - 1000);
      end
   endtask

   // query mostly inside the table span, sometimes on a point or outside
   function automatic int pick_query();
      int          lo, hi, t;
      int unsigned sel;
      lo = tbl_x[0];
      hi = tbl_x[points_in_use - 1];
      if (lo > hi) begin
         t  = lo;
         lo = hi;
         hi = t;
      end
      sel = $urandom_range(0, 19);
      if (sel < 11)
         return lo + int'($urandom_range(0, hi - lo));
      if (sel < 14)
         return tbl_x[$urandom_range(0, points_in_use - 1)];
      if (sel < 16)
         return (lo == VALUE_MIN) ? VALUE_MIN : lo - 1 - int'($urandom_range(0, lo + 32767));
      if (sel < 18)
         return (hi == VALUE_MAX) ? VALUE_MAX : hi + 1 + int'($urandom_range(0, 32766 - hi));
      return random_value();
   endfunction

   // result receiver: long hold-off on request, otherwise a wandering pattern
   always @(negedge clock) begin : receiver
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            flow_mode = flow_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 400);
         end
         mode_left--;
         case (flow_mode)
            FLOW_FREE:  rsp_stall <= 1'b0;
            FLOW_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            FLOW_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:    rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // watchdog on cycles with no handshake on any port
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_psel && csr_penable && csr_pwrite && csr_pready))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      int unsigned k, lookups, sel, count, phase, hold_phase;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // every slot written once, so no lookup reaches an unwritten entry
      for (k = 0; k < MAX_POINTS; k++)
         send_load(8'(k), VALUE_MIN + int'(k * 256 + $urandom_range(0, 255)), random_value());

      // full-range rising segment at the reset count of two
      send_load(0, VALUE_MIN, VALUE_MIN);
      send_load(1, VALUE_MAX, VALUE_MAX);
      send_lookup(VALUE_MIN);
      send_lookup(VALUE_MAX);
      send_lookup(0);
      // full-range falling segment
      send_load(0, VALUE_MIN, VALUE_MAX);
      send_load(1, VALUE_MAX, VALUE_MIN);
      send_lookup(1);
      send_lookup(-1);
      // flat segment
      send_load(1, VALUE_MAX, VALUE_MAX);
      send_lookup(12345);
      // zero x spread, then just below and just above it
      send_load(0, 5, 100);
      send_load(1, 5, -200);
      send_lookup(5);
      send_lookup(4);
      send_lookup(6);
      // x decreasing along the table
      send_load(0, 100, 7);
      send_load(1, -100, -7);
      send_lookup(0);
      send_lookup(VALUE_MAX);

      // counts below two and above the table size, and the unused register
      drain_and_settle(SETTLE_CYCLES);
      set_point_count(0);
      send_lookup(-150);
      drain_and_settle(SETTLE_CYCLES);
      set_point_count(1);
      send_lookup(150);
      drain_and_settle(SETTLE_CYCLES);
      set_point_count(511);
      send_lookup(VALUE_MAX);
      drain_and_settle(SETTLE_CYCLES);
      write_register(REG_SPARE, $urandom());
      send_lookup(random_value());

      // random phases: new count, fresh table, then lookups with some noise
      phase      = 0;
      hold_phase = $urandom_range(3, 10);
      while (sent_count < TARGET_REQUESTS) begin
         drain_and_settle(SETTLE_CYCLES);
         sel = $urandom_range(0, 19);
         if (phase == hold_phase)
            count = $urandom_range(2, 6);
         else if (sel == 0)
            count = $urandom_range(0, 1);
         else if (sel == 1)
            count = MAX_POINTS;
         else if (sel == 2)
            count = $urandom_range(MAX_POINTS + 1, 511);
         else if (sel < 6)
            count = $urandom_range(13, 48);
         else
            count = $urandom_range(2, 12);
         set_point_count(count);
         if ($urandom_range(0, 4) == 0)
            write_register(REG_SPARE, $urandom());
         build_table(points_in_use);
         lookups = (points_in_use > 64) ? $urandom_range(2, 5) : $urandom_range(6, 24);
         // long result hold-off while requests keep coming
         if (phase == hold_phase) begin
            hold_request = 1'b1;
            lookups      = 24;
         end
         for (k = 0; k < lookups; k++) begin
            if ($urandom_range(0, 19) == 0)
               send_load(8'($urandom_range(0, 255)), random_value(), random_value());
            // sender pause until every result is back
            if ($urandom_range(0, 39) == 0) begin
               req_valid <= 1'b0;
               burst_left = 0;
               while (lookups_pending != 0) @(negedge clock);
               @(negedge clock);
            end
            send_lookup(pick_query());
         end
         phase++;
      end

      drain_and_settle(TAIL_CYCLES);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
